// ===== sv/rcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the rank count sort unit.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // control of the element and rank memories
    typedef struct packed {
        logic rd_en;
        logic elem_wr_en;
        logic rank_wr_en;
    } rank_ctrl_t;

endpackage

// ===== sv/rcs_rank_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_rank_mem
// Element and rank memories with a registered read port and the shared
// signed compare unit that tests each stored element against the new key.
// ----------------------------------------------------------------------------
module rcs_rank_mem #(
    parameter int MAX_N = 64
) (
    input  logic                        aclk,
    input  rcs_pkg::rank_ctrl_t         ctrl,
    input  logic [$clog2(MAX_N)-1:0]    rd_addr,
    input  logic [$clog2(MAX_N)-1:0]    wr_addr,
    input  rcs_pkg::data_t              elem_wdata,
    input  logic [$clog2(MAX_N)-1:0]    rank_wdata,
    input  rcs_pkg::data_t              key,
    output rcs_pkg::data_t              elem_q,
    output logic [$clog2(MAX_N)-1:0]    rank_q,
    output logic                        le
);

    localparam int AW = $clog2(MAX_N);

    rcs_pkg::data_t  elem_mem [0:MAX_N-1];
    logic [AW-1:0]   rank_mem [0:MAX_N-1];

    always_ff @(posedge aclk) begin
        if (ctrl.elem_wr_en) begin
            elem_mem[wr_addr] <= elem_wdata;
        end
        if (ctrl.rd_en) begin
            elem_q <= elem_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rank_wr_en) begin
            rank_mem[wr_addr] <= rank_wdata;
        end
        if (ctrl.rd_en) begin
            rank_q <= rank_mem[rd_addr];
        end
    end

    // stored element ranks before the key
    assign le = (elem_q <= key);

endmodule

// ===== sv/rcs_sort_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_sort_buf
// Sorted-order memory filled by rank scatter, read out in ascending order
// into the result register of the output channel.
// ----------------------------------------------------------------------------
module rcs_sort_buf #(
    parameter int MAX_N = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_N)-1:0]    wr_addr,
    input  rcs_pkg::data_t              wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_N)-1:0]    rd_addr,
    input  logic                        rd_last,
    output logic                        can_issue,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rcs_pkg::data_t              m_sorted_value,
    output logic                        m_last_out
);

    rcs_pkg::data_t sort_mem [0:MAX_N-1];

    logic valid_reg;
    logic valid_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sort_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            m_sorted_value <= sort_mem[rd_addr];
            m_last_out     <= rd_last;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (rd_en) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign can_issue = !valid_reg || m_ready;
    assign m_valid   = valid_reg;

endmodule

// ===== sv/rank_count_sort_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_count_sort_unit
// Stable comparison-counting sort of signed 32-bit values.
// ----------------------------------------------------------------------------
// an item holds off the input through the single compare walk over the n stored
//   values and its store; a full store drops it
// the last item adds rank scatter and readout; results leave at one per
//   cycle while m_ready holds
// synchronous active-low reset empties the store; memories are not cleared
// ----------------------------------------------------------------------------
module rank_count_sort_unit #(
    parameter int MAX_N = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rcs_pkg::data_t      s_value,
    input  logic                s_last_in,
    output logic                m_valid,
    input  logic                m_ready,
    output rcs_pkg::data_t      m_sorted_value,
    output logic                m_last_out
);

    localparam int AW = $clog2(MAX_N);
    localparam int CW = $clog2(MAX_N + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_N);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_STORE   = 3'd2;
    localparam logic [2:0] ST_SCATTER = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pv_reg, pv_next;
    logic [AW-1:0]    paddr_reg, paddr_next;
    logic [AW-1:0]    acc_reg, acc_next;
    rcs_pkg::data_t   nv_reg, nv_next;
    logic             last_reg, last_next;

    rcs_pkg::rank_ctrl_t ctrl;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rank_wdata;
    rcs_pkg::data_t   elem_q;
    logic [AW-1:0]    rank_q;
    logic             le;

    logic             sort_wr_en;
    logic             sort_rd_en;
    logic             sort_rd_last;
    logic             can_issue;
    logic             issue;

    rcs_rank_mem #(
        .MAX_N (MAX_N)
    ) u_rank_mem (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .elem_wdata (nv_reg),
        .rank_wdata (rank_wdata),
        .key        (nv_reg),
        .elem_q     (elem_q),
        .rank_q     (rank_q),
        .le         (le)
    );

    rcs_sort_buf #(
        .MAX_N (MAX_N)
    ) u_sort_buf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr_en          (sort_wr_en),
        .wr_addr        (rank_q),
        .wr_data        (elem_q),
        .rd_en          (sort_rd_en),
        .rd_addr        (idx_reg[AW-1:0]),
        .rd_last        (sort_rd_last),
        .can_issue      (can_issue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out)
    );

    assign issue        = (idx_reg < count_reg);
    assign sort_rd_last = ((idx_reg + 1'b1) == count_reg);
    assign s_ready      = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pv_next    = 1'b0;
        paddr_next = paddr_reg;
        acc_next   = acc_reg;
        nv_next    = nv_reg;
        last_next  = last_reg;
        ctrl       = '0;
        rd_addr    = idx_reg[AW-1:0];
        wr_addr    = paddr_reg;
        rank_wdata = rank_q + 1'b1;
        sort_wr_en = 1'b0;
        sort_rd_en = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    nv_next   = s_value;
                    last_next = s_last_in;
                    idx_next  = '0;
                    acc_next  = '0;
                    if (count_reg < MAX_CNT) begin
                        state_next = ST_SCAN;
                    end else if (s_last_in) begin
                        state_next = ST_SCATTER;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    ctrl.rd_en = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    pv_next    = 1'b1;
                    paddr_next = idx_reg[AW-1:0];
                end
                if (pv_reg) begin
                    if (le) begin
                        acc_next = acc_reg + 1'b1;
                    end else begin
                        ctrl.rank_wr_en = 1'b1;
                    end
                end
                if (!issue && !pv_reg) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                ctrl.elem_wr_en = 1'b1;
                ctrl.rank_wr_en = 1'b1;
                wr_addr         = count_reg[AW-1:0];
                rank_wdata      = acc_reg;
                count_next      = count_reg + 1'b1;
                idx_next        = '0;
                state_next      = last_reg ? ST_SCATTER : ST_IDLE;
            end
            ST_SCATTER: begin
                if (issue) begin
                    ctrl.rd_en = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    pv_next    = 1'b1;
                end
                if (pv_reg) begin
                    sort_wr_en = 1'b1;
                end
                if (!issue && !pv_reg) begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
            end
            ST_EMIT: begin
                if (can_issue) begin
                    sort_rd_en = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    if (sort_rd_last) begin
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        paddr_reg <= paddr_next;
        acc_reg   <= acc_next;
        nv_reg    <= nv_next;
        last_reg  <= last_next;
    end

endmodule

// ===== sv/rcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the rank count sort unit, bound to the top level.
// ----------------------------------------------------------------------------
module rcs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_last_in,
    input logic                m_valid,
    input logic                m_ready,
    input rcs_pkg::data_t      m_sorted_value,
    input logic                m_last_out
);

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a last request starts the sort, so input is held off
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_in |=> !s_ready)
        else $error("input accepted while sort pending");

    // no result can appear in the cycle after a request is taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared directly after a request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_value)
            && $stable(m_last_out))
        else $error("stalled result changed");

endmodule

bind rank_count_sort_unit rcs_checker u_rcs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last_in      (s_last_in),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sorted_value (m_sorted_value),
    .m_last_out     (m_last_out)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rank count sort unit.
// ----------------------------------------------------------------------------
// Arrays of signed values are sent, each closed by a last flag. A stable
// sort predictor in the bench builds the expected run for every array. Each
// returned value and its last flag are checked in order. The run covers
// extremes, duplicates, single-element arrays and arrays that overflow the
// store. It goes through four idle phases and one long receiver hold.
// ----------------------------------------------------------------------------
module tb;
    typedef rcs_pkg::data_t data_t;

    localparam int    MAX_N        = 64;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    STALL_LIMIT  = 5000;
    localparam int    TAIL_CYCLES  = 50;
    localparam data_t DATA_MIN     = 32'sh8000_0000;
    localparam data_t DATA_MAX     = 32'sh7fff_ffff;

    typedef struct packed {
        data_t value;
        logic  last;
    } sort_item_t;

    logic  aclk           = 1'b0;
    logic  aresetn        = 1'b0;
    logic  s_valid        = 1'b0;
    logic  s_ready;
    data_t s_value        = '0;
    logic  s_last_in      = 1'b0;
    logic  m_valid;
    logic  m_ready        = 1'b0;
    data_t m_sorted_value;
    logic  m_last_out;

    sort_item_t pending_items[$];
    sort_item_t expected_sorted[$];
    data_t      held_values[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int offered_cnt    = 0;
    int taken_cnt      = 0;
    int quiet_cycles   = 0;
    int errors         = 0;
    int arrays_done    = 0;
    int dropped_cnt    = 0;
    int results_cnt    = 0;

    sort_item_t next_item;
    sort_item_t exp_item;

    rank_count_sort_unit #(
        .MAX_N(MAX_N)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_out    (m_last_out)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // stable sort of the held array once its last request arrives
    function automatic void absorb_value(data_t v, logic last);
        data_t      ordered [MAX_N];
        sort_item_t item;
        int         n;
        int         pos;
        if (held_values.size() < MAX_N) begin
            held_values.push_back(v);
        end else begin
            dropped_cnt++;
        end
        if (!last) begin
            return;
        end
        n = held_values.size();
        for (int i = 0; i < n; i++) begin
            pos = 0;
            for (int j = 0; j < n; j++) begin
                if (held_values[j] < held_values[i] ||
                    (held_values[j] == held_values[i] && j < i)) begin
                    pos++;
                end
            end
            ordered[pos] = held_values[i];
        end
        for (int i = 0; i < n; i++) begin
            item.value = ordered[i];
            item.last  = (i == n - 1);
            expected_sorted.push_back(item);
        end
        held_values.delete();
        arrays_done++;
    endfunction

    function automatic data_t pick_value(int flavor);
        case (flavor)
            0: begin
                return data_t'($urandom);
            end
            1: begin
                return data_t'(int'($urandom_range(8)) - 4);
            end
            default: begin
                case ($urandom_range(5))
                    0: return DATA_MIN;
                    1: return DATA_MAX;
                    2: return data_t'(0);
                    3: return data_t'(-1);
                    4: return data_t'($urandom);
                    default: return data_t'(int'($urandom_range(2)) - 1);
                endcase
            end
        endcase
    endfunction

    task automatic push_item(data_t v, logic last);
        sort_item_t item;
        item.value = v;
        item.last  = last;
        pending_items.push_back(item);
    endtask

    task automatic queue_array(int len, int flavor);
        for (int i = 0; i < len; i++) begin
            push_item(pick_value(flavor), i == len - 1);
        end
    endtask

    task automatic fill_phase(int n_items);
        int queued;
        int len;
        queued = 0;
        while (queued < n_items) begin
            len = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            queue_array(len, $urandom_range(2));
            queued += len;
        end
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_sorted.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || taken_cnt == offered_cnt) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                s_value   <= next_item.value;
                s_last_in <= next_item.last;
                s_valid   <= 1'b1;
                offered_cnt++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result backpressure, with an occasional long hold
    always @(negedge aclk) begin
        if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // request monitor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            taken_cnt++;
            absorb_value(s_value, s_last_in);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_cnt++;
            if (expected_sorted.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, value %0d last %0b",
                         $time, m_sorted_value, m_last_out);
            end else begin
                exp_item = expected_sorted.pop_front();
                if (m_sorted_value !== exp_item.value) begin
                    errors++;
                    $display("%0t: sorted_value expected %0d, got %0d",
                             $time, exp_item.value, m_sorted_value);
                end
                if (m_last_out !== exp_item.last) begin
                    errors++;
                    $display("%0t: last_out expected %0b, got %0b",
                             $time, exp_item.last, m_last_out);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase 0: no idling, directed arrays first
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_item(DATA_MAX, 1'b1);
        push_item(DATA_MIN, 1'b0);
        push_item(DATA_MAX, 1'b0);
        push_item(data_t'(0), 1'b0);
        push_item(data_t'(-1), 1'b0);
        push_item(data_t'(1), 1'b0);
        push_item(DATA_MIN, 1'b0);
        push_item(DATA_MAX, 1'b1);
        push_item(data_t'(5), 1'b0);
        push_item(data_t'(5), 1'b0);
        push_item(data_t'(-5), 1'b0);
        push_item(data_t'(5), 1'b1);
        for (int k = 3; k >= -2; k--) begin
            push_item(data_t'(k), k == -2);
        end
        for (int k = -2; k <= 2; k++) begin
            push_item(data_t'(k), k == 2);
        end
        hold_request++;
        queue_array(MAX_N, 0);
        queue_array(MAX_N + 2, 2);
        fill_phase(40);
        drain();

        // phase 1: sender mostly idle
        send_idle_pct = 87;
        fill_phase(110);
        drain();

        // phase 2: receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        fill_phase(110);
        drain();

        // phase 3: both idle now and then
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        fill_phase(110);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_sorted.size() != 0) begin
            errors++;
            $display("%0t: %0d expected values never returned", $time, expected_sorted.size());
        end
        $display("%0d requests in %0d arrays, %0d dropped on a full store, %0d values checked",
                 taken_cnt, arrays_done, dropped_cnt, results_cnt);
        $display("idle phases: none, sender 87%%, receiver 87%%, both 15%%; one long hold");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
